[rtl/core/surface_normal_unit_vector_unit_defines.svh]
// assertion macros for the surface normal unit
`ifndef SURFACE_NORMAL_UNIT_VECTOR_UNIT_DEFINES_SVH
`define SURFACE_NORMAL_UNIT_VECTOR_UNIT_DEFINES_SVH

// condition must hold in the same cycle
`define SNUV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the following cycle
`define SNUV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/snuv_pkg.sv]
// shared types and constants of the surface normal unit
package snuv_pkg;

  localparam int IN_W       = 16;
  localparam int FRAC_BITS  = 14;
  localparam int OUT_W      = 16;
  localparam int LANES      = 3;
  localparam int PROD_W     = 2 * IN_W;
  localparam int VEC_W      = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int Q_W        = 2 * FRAC_BITS + 3;
  localparam int DIV_STEPS  = Q_W;
  localparam int RAD_W      = Q_W + 1;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int REM_W      = ROOT_W + 2;

  localparam logic signed [OUT_W-1:0] UNIT_ONE = OUT_W'(1 << FRAC_BITS);

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_PLANE = 2'd2,
    MODE_SPACE = 2'd3
  } mode_t;

  typedef logic [SQ_W-1:0] sq_t;
  typedef logic [LANES-1:0][SQ_W-1:0] sq_vec_t;
  typedef logic [LANES-1:0][Q_W-1:0] quo_vec_t;
  typedef logic [LANES-1:0][ROOT_W-1:0] root_vec_t;

  typedef struct packed {
    logic signed [IN_W-1:0] col1_x;
    logic signed [IN_W-1:0] col1_y;
    logic signed [IN_W-1:0] col1_z;
    logic signed [IN_W-1:0] col2_x;
    logic signed [IN_W-1:0] col2_y;
    logic signed [IN_W-1:0] col2_z;
    logic                   last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    area_zero;
    logic                    last_out;
  } out_item_t;

  // per-request information that rides alongside the arithmetic
  typedef struct packed {
    mode_t            mode;
    logic             last;
    logic             zero;
    logic [LANES-1:0] neg;
  } side_t;

endpackage

[rtl/core/snuv_front.sv]
// front end: normal vector (cross product in space mode), squares and squared length over four stages
module snuv_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  snuv_pkg::in_item_t in_item,
  input  snuv_pkg::mode_t    mode,
  output logic               out_valid,
  output snuv_pkg::side_t    out_side,
  output snuv_pkg::sq_t      out_den,
  output snuv_pkg::sq_vec_t  out_num
);
  import snuv_pkg::*;

  logic [3:0] vld;

  // stage one: products
  logic signed [PROD_W-1:0] p [6];
  logic signed [IN_W-1:0]   s1_ax, s1_ay;
  mode_t                    s1_mode, s2_mode;
  logic                     s1_last, s2_last;

  // stage two: vector components
  logic signed [VEC_W-1:0]  v [LANES];

  // stage three: squares
  sq_t                      s3_sq [LANES];
  side_t                    s3_side;

  // stage four: length squared
  sq_t                      s4_sum;
  sq_vec_t                  s4_sq;
  side_t                    s4_side;

  logic [MAG_W-1:0]         mag [LANES];
  logic [LANES-1:0]         neg;

  // magnitudes of the components
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      neg[l] = v[l][VEC_W-1];
      mag[l] = neg[l] ? MAG_W'(-v[l]) : MAG_W'(v[l]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      p[0]    <= in_item.col1_y * in_item.col2_z;
      p[1]    <= in_item.col1_z * in_item.col2_y;
      p[2]    <= in_item.col1_z * in_item.col2_x;
      p[3]    <= in_item.col1_x * in_item.col2_z;
      p[4]    <= in_item.col1_x * in_item.col2_y;
      p[5]    <= in_item.col1_y * in_item.col2_x;
      s1_ax   <= in_item.col1_x;
      s1_ay   <= in_item.col1_y;
      s1_mode <= mode;
      s1_last <= in_item.last_point;

      case (s1_mode)
        MODE_SPACE: begin
          v[0] <= VEC_W'(p[0]) - VEC_W'(p[1]);
          v[1] <= VEC_W'(p[2]) - VEC_W'(p[3]);
          v[2] <= VEC_W'(p[4]) - VEC_W'(p[5]);
        end
        MODE_PLANE: begin
          v[0] <= VEC_W'(s1_ay);
          v[1] <= -VEC_W'(s1_ax);
          v[2] <= '0;
        end
        default: begin
          v[0] <= '0;
          v[1] <= '0;
          v[2] <= '0;
        end
      endcase
      s2_mode <= s1_mode;
      s2_last <= s1_last;

      for (int l = 0; l < LANES; l++) begin
        s3_sq[l] <= SQ_W'(mag[l]) * SQ_W'(mag[l]);
      end
      s3_side.mode <= s2_mode;
      s3_side.last <= s2_last;
      s3_side.zero <= 1'b0;
      s3_side.neg  <= neg;

      s4_sum <= s3_sq[0] + s3_sq[1] + s3_sq[2];
      for (int l = 0; l < LANES; l++) begin
        s4_sq[l] <= s3_sq[l];
      end
      s4_side.mode <= s3_side.mode;
      s4_side.last <= s3_side.last;
      s4_side.neg  <= s3_side.neg;
      s4_side.zero <= (s3_sq[0] == '0) && (s3_sq[1] == '0) && (s3_sq[2] == '0);
    end
  end

  assign out_valid = vld[3];
  assign out_side  = s4_side;
  assign out_den   = s4_sum;
  assign out_num   = s4_sq;

endmodule

[rtl/core/snuv_div.sv]
// restoring divider, one quotient bit per stage: floor(c^2 * 2^30 / s)
module snuv_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  snuv_pkg::side_t    in_side,
  input  snuv_pkg::sq_t      in_den,
  input  snuv_pkg::sq_vec_t  in_num,
  output logic               out_valid,
  output snuv_pkg::side_t    out_side,
  output snuv_pkg::quo_vec_t out_quo
);
  import snuv_pkg::*;

  logic [DIV_STEPS-1:0] vld;
  side_t                side_r  [DIV_STEPS];
  sq_t                  den_r   [DIV_STEPS];
  sq_vec_t              rem_r   [DIV_STEPS];
  quo_vec_t             quo_r   [DIV_STEPS];
  sq_vec_t              rem_src [DIV_STEPS];
  quo_vec_t             quo_src [DIV_STEPS];
  sq_t                  den_src [DIV_STEPS];
  logic [LANES-1:0]     feed    [DIV_STEPS];
  sq_vec_t              rem_next[DIV_STEPS];
  quo_vec_t             quo_next[DIV_STEPS];

  // stage sources: the first stage starts from c^2 / 2 and feeds c^2 bit zero
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_src[0][l] = in_num[l] >> 1;
      quo_src[0][l] = '0;
      feed[0][l]    = in_num[l][0];
    end
    den_src[0] = in_den;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_src[k] = rem_r[k-1];
      quo_src[k] = quo_r[k-1];
      den_src[k] = den_r[k-1];
      feed[k]    = '0;
    end
  end

  // shift, compare and subtract in every stage
  always_comb begin
    logic [SQ_W:0] trial;
    logic [SQ_W:0] dvs;
    for (int k = 0; k < DIV_STEPS; k++) begin
      dvs = {1'b0, den_src[k]};
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_src[k][l], feed[k][l]};
        if (trial >= dvs) begin
          rem_next[k][l] = SQ_W'(trial - dvs);
          quo_next[k][l] = {quo_src[k][l][Q_W-2:0], 1'b1};
        end else begin
          rem_next[k][l] = SQ_W'(trial);
          quo_next[k][l] = {quo_src[k][l][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS-2:0], in_valid};
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r     <= rem_next;
      quo_r     <= quo_next;
      den_r     <= den_src;
      side_r[0] <= in_side;
      for (int k = 1; k < DIV_STEPS; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];
  assign out_quo   = quo_r[DIV_STEPS-1];

endmodule

[rtl/core/snuv_sqrt.sv]
// integer square root, one root bit per stage
module snuv_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  snuv_pkg::side_t     in_side,
  input  snuv_pkg::quo_vec_t  in_rad,
  output logic                out_valid,
  output snuv_pkg::side_t     out_side,
  output snuv_pkg::root_vec_t out_root
);
  import snuv_pkg::*;

  typedef logic [LANES-1:0][RAD_W-1:0]  rad_vec_t;
  typedef logic [LANES-1:0][REM_W-1:0]  rem_vec_t;

  logic [SQRT_STEPS-1:0] vld;
  side_t                 side_r   [SQRT_STEPS];
  rad_vec_t              rad_r    [SQRT_STEPS];
  rem_vec_t              rem_r    [SQRT_STEPS];
  root_vec_t             root_r   [SQRT_STEPS];
  rad_vec_t              rad_src  [SQRT_STEPS];
  rem_vec_t              rem_src  [SQRT_STEPS];
  root_vec_t             root_src [SQRT_STEPS];
  rad_vec_t              rad_next [SQRT_STEPS];
  rem_vec_t              rem_next [SQRT_STEPS];
  root_vec_t             root_next[SQRT_STEPS];

  // stage sources
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rad_src[0][l]  = RAD_W'(in_rad[l]);
      rem_src[0][l]  = '0;
      root_src[0][l] = '0;
    end
    for (int k = 1; k < SQRT_STEPS; k++) begin
      rad_src[k]  = rad_r[k-1];
      rem_src[k]  = rem_r[k-1];
      root_src[k] = root_r[k-1];
    end
  end

  // bring down two radicand bits and try root*4+1
  always_comb begin
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] sub;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_src[k][l], rad_src[k][l][RAD_W-1 -: 2]};
        sub   = (REM_W+2)'({root_src[k][l], 2'b01});
        rad_next[k][l] = rad_src[k][l] << 2;
        if (trial >= sub) begin
          rem_next[k][l]  = REM_W'(trial - sub);
          root_next[k][l] = {root_src[k][l][ROOT_W-2:0], 1'b1};
        end else begin
          rem_next[k][l]  = REM_W'(trial);
          root_next[k][l] = {root_src[k][l][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[SQRT_STEPS-2:0], in_valid};
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r     <= rad_next;
      rem_r     <= rem_next;
      root_r    <= root_next;
      side_r[0] <= in_side;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld[SQRT_STEPS-1];
  assign out_side  = side_r[SQRT_STEPS-1];
  assign out_root  = root_r[SQRT_STEPS-1];

endmodule

[rtl/core/surface_normal_unit_vector_unit.sv]
// top level of the surface normal unit: unit normal from two jacobian columns
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------
//   input    | in_valid/in_stall  | in_data   (snuv_pkg::in_item_t)
//   output   | out_valid/out_stall| out_data  (snuv_pkg::out_item_t)
//   config   | mode_we            | mode_wdata (dimension mode)
//
// one request per cycle while the output is not stalled; 4 front stages, 31 divider
// stages (one quotient bit each), 16 square root stages, 1 output register
// reset clears all valid bits and sets the dimension mode to three
// a stalled output freezes the whole pipeline, and in_stall follows it
module surface_normal_unit_vector_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  snuv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output snuv_pkg::out_item_t out_data,
  input  logic                mode_we,
  input  logic [1:0]          mode_wdata
);
  import snuv_pkg::*;

  `include "surface_normal_unit_vector_unit_defines.svh"

  mode_t              mode;
  logic               en;
  logic               fe_valid, div_valid, sq_valid;
  side_t              fe_side, div_side, sq_side;
  sq_t                fe_den;
  sq_vec_t            fe_num;
  quo_vec_t           div_quo;
  root_vec_t          sq_root;
  logic signed [OUT_W-1:0] comp [LANES];
  out_item_t          out_next;

  // pipeline advances unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // dimension mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SPACE;
    end else if (mode_we) begin
      mode <= mode_t'(mode_wdata);
    end
  end

  snuv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .in_item  (in_data),
    .mode     (mode),
    .out_valid(fe_valid),
    .out_side (fe_side),
    .out_den  (fe_den),
    .out_num  (fe_num)
  );

  snuv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (fe_valid),
    .in_side  (fe_side),
    .in_den   (fe_den),
    .in_num   (fe_num),
    .out_valid(div_valid),
    .out_side (div_side),
    .out_quo  (div_quo)
  );

  snuv_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (div_valid),
    .in_side  (div_side),
    .in_rad   (div_quo),
    .out_valid(sq_valid),
    .out_side (sq_side),
    .out_root (sq_root)
  );

  // rounded magnitude is (root + 1) / 2, then the sign goes back on
  always_comb begin
    logic [ROOT_W:0] half;
    for (int l = 0; l < LANES; l++) begin
      half    = (ROOT_W+1)'(sq_root[l]) + (ROOT_W+1)'(1);
      comp[l] = sq_side.neg[l] ? -OUT_W'(half[ROOT_W:1]) : OUT_W'(half[ROOT_W:1]);
    end
  end

  // result formatting per mode
  always_comb begin
    out_next           = '0;
    out_next.last_out  = sq_side.last;
    case (sq_side.mode)
      MODE_LINE: begin
        out_next.normal_x = UNIT_ONE;
      end
      MODE_PLANE, MODE_SPACE: begin
        if (sq_side.zero) begin
          out_next.area_zero = 1'b1;
        end else begin
          out_next.normal_x = comp[0];
          out_next.normal_y = comp[1];
          out_next.normal_z = comp[2];
        end
      end
      default: begin
        out_next.area_zero = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

  // checks
  `SNUV_ASSERT_NOW(a_zero_len, clk, rst, out_valid && out_data.area_zero,
    (out_data.normal_x == '0) && (out_data.normal_y == '0) && (out_data.normal_z == '0),
    "zero length result with nonzero component")
  `SNUV_ASSERT_NOW(a_x_range, clk, rst, out_valid,
    (out_data.normal_x <= UNIT_ONE) && (out_data.normal_x >= -UNIT_ONE),
    "normal_x outside unit range")
  `SNUV_ASSERT_NOW(a_y_range, clk, rst, out_valid,
    (out_data.normal_y <= UNIT_ONE) && (out_data.normal_y >= -UNIT_ONE),
    "normal_y outside unit range")
  `SNUV_ASSERT_NEXT(a_freeze, clk, rst, !en, $stable(div_valid) && $stable(sq_valid),
    "pipeline moved while output held")

endmodule
